// ===== design/vcdq_pkg.sv =====
package vcdq_pkg;

  localparam int TAG_W   = 16;
  localparam int ENTRY_W = TAG_W + 1;

  localparam logic [1:0] REQ_ENQUEUE    = 2'd0;
  localparam logic [1:0] REQ_DEQUEUE    = 2'd1;
  localparam logic [1:0] REQ_CONNECT    = 2'd2;
  localparam logic [1:0] REQ_DISCONNECT = 2'd3;

  localparam logic [2:0] ST_ACCEPTED   = 3'd0;
  localparam logic [2:0] ST_NOT_CONN   = 3'd1;
  localparam logic [2:0] ST_AWAIT_KEY  = 3'd2;
  localparam logic [2:0] ST_CONGESTED  = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;
  localparam logic [2:0] ST_NOT_ENQ    = 3'd5;

  localparam logic [3:0] MAX_VIDEO_RESET = 4'd3;

endpackage

// ===== design/vcdq_ram.sv =====
module vcdq_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 17
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/video_congestion_drop_queue_unit.sv =====
// Channel  | Handshake             | Payload
// input    | in_valid / in_ready   | req_type, is_video, is_keyframe, packet_tag
// result   | res_valid / res_ready | enqueue_status .. congestion_events
// config   | cfg_wr_en             | cfg_wr_data (max_video_queued)
//
// One word at a time: each word is accepted, then loaded into the result register.
// A congestion flush first compacts the queue: the compaction walks the live entries
// through the one read port of the entry memory, one entry per cycle.
// Reset (rst, synchronous) empties the queue, drops the link and sets the limit to 3.
// A stalled result holds the next word in in_ready low; config writes are always taken.
module video_congestion_drop_queue_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic        is_video,
  input  logic        is_keyframe,
  input  logic [15:0] packet_tag,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [2:0]  enqueue_status,
  output logic        keyframe_request,
  output logic [4:0]  flushed_count,
  output logic        out_valid,
  output logic [15:0] out_tag,
  output logic        out_is_video,
  output logic [31:0] congestion_events,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int XW = CW + 4;
  localparam int EW = vcdq_pkg::ENTRY_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FLUSH = 3'b010,
    S_EMIT  = 3'b100
  } state_t;

  state_t        state;
  logic [PW-1:0] head;
  logic [CW-1:0] count;
  logic [CW-1:0] video_count;
  logic          await_keyframe;
  logic          link_up;
  logic [31:0]   congestion_total;
  logic [3:0]    max_video_queued;

  logic [2:0]    pend_status;
  logic          pend_kreq;
  logic [4:0]    pend_flushed;
  logic          pend_deq;

  logic [CW-1:0] rcnt;
  logic [CW-1:0] wcnt;
  logic [CW-1:0] gone;
  logic [PW-1:0] rp;
  logic [PW-1:0] wp;
  logic          rd_pend;
  logic          fl_key;
  logic [15:0]   fl_tag;

  logic          ram_we;
  logic [PW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic          ram_re;
  logic [PW-1:0] ram_raddr;
  logic [EW-1:0] rd_data;

  logic          in_fire;
  logic          full;
  logic          blocked;
  logic          congest;
  logic [PW-1:0] tail;
  logic [CW:0]   tail_sum;
  logic [CW+4:0] gone_x;
  logic          flush_done;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_ready   = (state == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign full       = (count == CW'(QUEUE_DEPTH));
  assign blocked    = await_keyframe && !is_keyframe;
  assign congest    = XW'(video_count) >= XW'(max_video_queued);
  assign tail_sum   = (CW+1)'(head) + (CW+1)'(count);
  assign tail       = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                      PW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : PW'(tail_sum);
  assign gone_x     = (CW+5)'(gone);
  assign flush_done = (rcnt == count) && !rd_pend;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tail;
    ram_wdata = {packet_tag, is_video};
    ram_re    = 1'b0;
    ram_raddr = head;
    unique case (state)
      S_IDLE: begin
        if (in_fire && req_type == vcdq_pkg::REQ_ENQUEUE && link_up && !full) begin
          if (!is_video || (!blocked && !congest)) begin
            ram_we = 1'b1;
          end
        end
        if (in_fire && req_type == vcdq_pkg::REQ_DEQUEUE && count != '0) begin
          ram_re = 1'b1;
        end
      end
      S_FLUSH: begin
        if (rcnt != count) begin
          ram_re    = 1'b1;
          ram_raddr = rp;
        end
        ram_waddr = wp;
        if (rd_pend && !rd_data[0]) begin
          ram_we    = 1'b1;
          ram_wdata = rd_data;
        end else if (flush_done && fl_key && wcnt != CW'(QUEUE_DEPTH)) begin
          ram_we    = 1'b1;
          ram_wdata = {fl_tag, 1'b1};
        end
      end
      S_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  vcdq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (PW),
    .DW    (EW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      head             <= '0;
      count            <= '0;
      video_count      <= '0;
      await_keyframe   <= 1'b0;
      link_up          <= 1'b0;
      congestion_total <= '0;
      max_video_queued <= vcdq_pkg::MAX_VIDEO_RESET;
      res_valid        <= 1'b0;
      rd_pend          <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_video_queued <= cfg_wr_data;
      end
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            pend_status  <= vcdq_pkg::ST_NOT_ENQ;
            pend_kreq    <= 1'b0;
            pend_flushed <= '0;
            pend_deq     <= 1'b0;
            state        <= S_EMIT;
            unique case (req_type)
              vcdq_pkg::REQ_ENQUEUE: begin
                if (!link_up) begin
                  pend_status <= vcdq_pkg::ST_NOT_CONN;
                end else if (is_video) begin
                  if (blocked) begin
                    pend_status <= vcdq_pkg::ST_AWAIT_KEY;
                  end else if (congest) begin
                    congestion_total <= congestion_total + 32'd1;
                    rcnt    <= '0;
                    wcnt    <= '0;
                    gone    <= '0;
                    rp      <= head;
                    wp      <= head;
                    rd_pend <= 1'b0;
                    fl_key  <= is_keyframe;
                    fl_tag  <= packet_tag;
                    state   <= S_FLUSH;
                    if (!is_keyframe) begin
                      await_keyframe <= 1'b1;
                      pend_kreq      <= 1'b1;
                      pend_status    <= vcdq_pkg::ST_CONGESTED;
                    end
                  end else if (full) begin
                    pend_status <= vcdq_pkg::ST_FULL;
                  end else begin
                    count          <= count + 1'b1;
                    video_count    <= video_count + 1'b1;
                    await_keyframe <= 1'b0;
                    pend_status    <= vcdq_pkg::ST_ACCEPTED;
                  end
                end else if (full) begin
                  pend_status <= vcdq_pkg::ST_FULL;
                end else begin
                  count       <= count + 1'b1;
                  pend_status <= vcdq_pkg::ST_ACCEPTED;
                end
              end
              vcdq_pkg::REQ_DEQUEUE: begin
                if (count != '0) begin
                  pend_deq <= 1'b1;
                  head     <= ptr_inc(head);
                  count    <= count - 1'b1;
                end
              end
              vcdq_pkg::REQ_CONNECT: begin
                count          <= '0;
                video_count    <= '0;
                await_keyframe <= 1'b0;
                link_up        <= 1'b1;
              end
              vcdq_pkg::REQ_DISCONNECT: begin
                count          <= '0;
                video_count    <= '0;
                await_keyframe <= 1'b0;
                link_up        <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        S_FLUSH: begin
          if (rcnt != count) begin
            rp   <= ptr_inc(rp);
            rcnt <= rcnt + 1'b1;
          end
          rd_pend <= (rcnt != count);
          if (rd_pend) begin
            if (rd_data[0]) begin
              gone <= gone + 1'b1;
            end else begin
              wp   <= ptr_inc(wp);
              wcnt <= wcnt + 1'b1;
            end
          end
          if (flush_done) begin
            count        <= wcnt;
            video_count  <= '0;
            pend_flushed <= gone_x[4:0];
            state        <= S_EMIT;
            if (fl_key) begin
              if (wcnt == CW'(QUEUE_DEPTH)) begin
                pend_status <= vcdq_pkg::ST_FULL;
              end else begin
                count          <= wcnt + 1'b1;
                video_count    <= CW'(1);
                await_keyframe <= 1'b0;
                pend_status    <= vcdq_pkg::ST_ACCEPTED;
              end
            end
          end
        end
        S_EMIT: begin
          if (!res_valid || res_ready) begin
            res_valid         <= 1'b1;
            enqueue_status    <= pend_status;
            keyframe_request  <= pend_kreq;
            flushed_count     <= pend_flushed;
            out_valid         <= pend_deq;
            out_tag           <= pend_deq ? rd_data[EW-1:1] : '0;
            out_is_video      <= pend_deq && rd_data[0];
            congestion_events <= congestion_total;
            state             <= S_IDLE;
            if (pend_deq && rd_data[0] && video_count != '0) begin
              video_count <= video_count - 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/vcdq_checker.sv =====
module vcdq_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [2:0]  enqueue_status,
  input logic        keyframe_request,
  input logic [4:0]  flushed_count,
  input logic        out_valid,
  input logic [15:0] out_tag,
  input logic        out_is_video,
  input logic [31:0] congestion_events
);

  a_kreq_congested: assert property (@(posedge clk) disable iff (rst)
    res_valid && (keyframe_request || enqueue_status == vcdq_pkg::ST_CONGESTED)
      |-> keyframe_request && enqueue_status == vcdq_pkg::ST_CONGESTED)
    else $error("keyframe request without congested drop");

  a_deq_not_enq: assert property (@(posedge clk) disable iff (rst)
    res_valid && out_valid |-> enqueue_status == vcdq_pkg::ST_NOT_ENQ
      && flushed_count == 5'd0 && !keyframe_request)
    else $error("dequeue word carries enqueue fields");

  a_empty_deq: assert property (@(posedge clk) disable iff (rst)
    res_valid && !out_valid |-> out_tag == 16'd0 && !out_is_video)
    else $error("dequeue fields set without an entry");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(enqueue_status)
      && $stable(out_tag) && $stable(congestion_events))
    else $error("stalled result word changed");

endmodule

bind video_congestion_drop_queue_unit vcdq_checker u_vcdq_checker (.*);
